FILE: hw/rtl/ter3d_pkg.sv
package ter3d_pkg;

  typedef logic [2:0][31:0] vec_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_OFFSET_Z  = 3'd2,
    REG_ROLL_CS   = 3'd3,
    REG_PITCH_CS  = 3'd4,
    REG_YAW_CS    = 3'd5
  } reg_idx_e;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned NUM_ROT  = 3;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [31:0] OFFSET_RST = 32'h0000_0000;
  localparam logic [31:0] CS_RST     = 32'h4000_0000;

  // axis indices per rotation: u' = u*c + v*s, v' = v*c - u*s, p passes
  localparam int unsigned ROT_U [NUM_ROT] = '{1, 2, 0};
  localparam int unsigned ROT_V [NUM_ROT] = '{2, 0, 1};
  localparam int unsigned ROT_P [NUM_ROT] = '{0, 1, 2};

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half up from q.14 scaling, then saturate
  function automatic logic [31:0] rescale(input logic signed [48:0] v);
    logic signed [49:0] r;
    logic signed [49:0] sh;
    r  = {v[48], v} + 50'sd8192;
    sh = r >>> 14;
    return sat32(sh[35:0]);
  endfunction

endpackage

FILE: hw/rtl/translate_and_euler_rotate_3d.sv
// Streaming 3-D point transform: adds the programmed offset to each point, then
// rotates it about x, y and z using the programmed Q1.14 cosine/sine pairs.
// A point is accepted on any cycle with start high; busy is always low, so one
// point per clock is sustained. The result appears on strobe_o after passing
// seven register stages and is held for one cycle only, since the receiver
// cannot stall. The stages are the offset add, then a multiply stage and a
// sum/round/saturate stage for each of the three rotations.
// Program the registers only while no point is in flight.
module translate_and_euler_rotate_3d
  import ter3d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  logic                last_point_i,
  output logic                strobe_o,
  output logic signed [31:0]  moved_x_o,
  output logic signed [31:0]  moved_y_o,
  output logic signed [31:0]  moved_z_o,
  output logic                last_moved_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned LATENCY = 7;

  logic [31:0] cfg_q [NUM_REGS];
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_OFFSET_X] <= OFFSET_RST;
      cfg_q[REG_OFFSET_Y] <= OFFSET_RST;
      cfg_q[REG_OFFSET_Z] <= OFFSET_RST;
      cfg_q[REG_ROLL_CS]  <= CS_RST;
      cfg_q[REG_PITCH_CS] <= CS_RST;
      cfg_q[REG_YAW_CS]   <= CS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OFFSET_X: cfg_q[REG_OFFSET_X] <= pwdata;
        REG_OFFSET_Y: cfg_q[REG_OFFSET_Y] <= pwdata;
        REG_OFFSET_Z: cfg_q[REG_OFFSET_Z] <= pwdata;
        REG_ROLL_CS:  cfg_q[REG_ROLL_CS]  <= pwdata;
        REG_PITCH_CS: cfg_q[REG_PITCH_CS] <= pwdata;
        REG_YAW_CS:   cfg_q[REG_YAW_CS]   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_OFFSET_X: prdata = cfg_q[REG_OFFSET_X];
      REG_OFFSET_Y: prdata = cfg_q[REG_OFFSET_Y];
      REG_OFFSET_Z: prdata = cfg_q[REG_OFFSET_Z];
      REG_ROLL_CS:  prdata = cfg_q[REG_ROLL_CS];
      REG_PITCH_CS: prdata = cfg_q[REG_PITCH_CS];
      REG_YAW_CS:   prdata = cfg_q[REG_YAW_CS];
      default:      prdata = '0;
    endcase
  end

  // offset stage
  logic             in_acc;
  vec_t             ofs_pt_q;
  logic             ofs_last_q;
  logic             ofs_vld_q;
  logic signed [32:0] sum_x, sum_y, sum_z;

  assign in_acc = start & ~busy;
  assign sum_x  = {point_x_i[31], point_x_i} + {cfg_q[REG_OFFSET_X][31], cfg_q[REG_OFFSET_X]};
  assign sum_y  = {point_y_i[31], point_y_i} + {cfg_q[REG_OFFSET_Y][31], cfg_q[REG_OFFSET_Y]};
  assign sum_z  = {point_z_i[31], point_z_i} + {cfg_q[REG_OFFSET_Z][31], cfg_q[REG_OFFSET_Z]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_vld_q <= 1'b0;
    end else begin
      ofs_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_pt_q[0] <= sat32({{3{sum_x[32]}}, sum_x});
    ofs_pt_q[1] <= sat32({{3{sum_y[32]}}, sum_y});
    ofs_pt_q[2] <= sat32({{3{sum_z[32]}}, sum_z});
    ofs_last_q  <= last_point_i;
  end

  vec_t stg_pt   [NUM_ROT+1];
  logic stg_last [NUM_ROT+1];
  logic stg_vld  [NUM_ROT+1];

  assign stg_pt[0]   = ofs_pt_q;
  assign stg_last[0] = ofs_last_q;
  assign stg_vld[0]  = ofs_vld_q;

  for (genvar r = 0; r < NUM_ROT; r++) begin : g_rot
    localparam int unsigned U = ROT_U[r];
    localparam int unsigned V = ROT_V[r];
    localparam int unsigned P = ROT_P[r];

    logic signed [15:0] cos_v, sin_v;
    logic signed [31:0] u_v, v_v;

    logic signed [47:0] uc_q, vs_q, vc_q, us_q;
    logic [31:0]        pass_q;
    logic               mul_last_q, mul_vld_q;

    vec_t               rot_pt_q;
    logic               rot_last_q, rot_vld_q;

    assign cos_v = $signed(cfg_q[REG_ROLL_CS + r][31:16]);
    assign sin_v = $signed(cfg_q[REG_ROLL_CS + r][15:0]);
    assign u_v   = $signed(stg_pt[r][U]);
    assign v_v   = $signed(stg_pt[r][V]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_vld_q <= 1'b0;
        rot_vld_q <= 1'b0;
      end else begin
        mul_vld_q <= stg_vld[r];
        rot_vld_q <= mul_vld_q;
      end
    end

    // multiply stage
    always_ff @(posedge clk_i) begin
      uc_q       <= u_v * cos_v;
      vs_q       <= v_v * sin_v;
      vc_q       <= v_v * cos_v;
      us_q       <= u_v * sin_v;
      pass_q     <= stg_pt[r][P];
      mul_last_q <= stg_last[r];
    end

    // sum, round and saturate stage
    always_ff @(posedge clk_i) begin
      rot_pt_q[U] <= rescale({uc_q[47], uc_q} + {vs_q[47], vs_q});
      rot_pt_q[V] <= rescale({vc_q[47], vc_q} - {us_q[47], us_q});
      rot_pt_q[P] <= pass_q;
      rot_last_q  <= mul_last_q;
    end

    assign stg_pt[r+1]   = rot_pt_q;
    assign stg_last[r+1] = rot_last_q;
    assign stg_vld[r+1]  = rot_vld_q;
  end

  assign strobe_o     = stg_vld[NUM_ROT];
  assign moved_x_o    = $signed(stg_pt[NUM_ROT][0]);
  assign moved_y_o    = $signed(stg_pt[NUM_ROT][1]);
  assign moved_z_o    = $signed(stg_pt[NUM_ROT][2]);
  assign last_moved_o = stg_last[NUM_ROT];

  // every accepted request produces a result strobe, and every strobe comes from an accepted request
  a_req_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##LATENCY strobe_o)
    else $error("accepted request did not produce a result");

  a_result_from_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(in_acc, LATENCY))
    else $error("result strobe without a matching request");

  a_last_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> last_moved_o == $past(last_point_i, LATENCY))
    else $error("last flag does not match its request");

  a_mid_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld[1] |-> $past(ofs_vld_q, 2))
    else $error("roll stage valid out of step with offset stage");

endmodule

FILE: tb/tb_translate_and_euler_rotate_3d.sv
`timescale 1ns / 1ps

module tb_translate_and_euler_rotate_3d
  import ter3d_pkg::*;
;

  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 60;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned POINTS_PER_SET = 50;

  // indexes past the register file, writes there must be dropped
  localparam logic [2:0] SPARE_IDX_A = 3'd6;
  localparam logic [2:0] SPARE_IDX_B = 3'd7;

  localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } point_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [31:0]       point_x_i = '0;
  logic signed [31:0]       point_y_i = '0;
  logic signed [31:0]       point_z_i = '0;
  logic                     last_point_i = 1'b0;
  logic                     strobe_o;
  logic signed [31:0]       moved_x_o;
  logic signed [31:0]       moved_y_o;
  logic signed [31:0]       moved_z_o;
  logic                     last_moved_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  logic [31:0]              cfg_shadow [NUM_REGS];
  point_t                   pending_q [$];
  point_t                   expected_q [$];
  point_t                   on_wire;
  int unsigned              burst_left = 1;
  int unsigned              gap_left = 0;
  int unsigned              mismatches = 0;
  int unsigned              idle_cycles = 0;

  translate_and_euler_rotate_3d dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .strobe_o     (strobe_o),
    .moved_x_o    (moved_x_o),
    .moved_y_o    (moved_y_o),
    .moved_z_o    (moved_z_o),
    .last_moved_o (last_moved_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > longint'(Q16_MAX)) begin
      return longint'(Q16_MAX);
    end
    if (v < longint'(Q16_MIN)) begin
      return longint'(Q16_MIN);
    end
    return v;
  endfunction

  // q.14 product back to q16.16, half rounds towards plus infinity
  function automatic longint q14_round(longint v);
    return clamp32((v + 64'sd8192) >>> 14);
  endfunction

  function automatic longint cos_part(logic [31:0] cs);
    return longint'($signed(cs[31:16]));
  endfunction

  function automatic longint sin_part(logic [31:0] cs);
    return longint'($signed(cs[15:0]));
  endfunction

  function automatic point_t transform_point(point_t p);
    longint x, y, z, c, s, nx, ny, nz;
    point_t r;
    x = clamp32(longint'($signed(p.x)) + longint'($signed(cfg_shadow[REG_OFFSET_X])));
    y = clamp32(longint'($signed(p.y)) + longint'($signed(cfg_shadow[REG_OFFSET_Y])));
    z = clamp32(longint'($signed(p.z)) + longint'($signed(cfg_shadow[REG_OFFSET_Z])));
    c = cos_part(cfg_shadow[REG_ROLL_CS]);
    s = sin_part(cfg_shadow[REG_ROLL_CS]);
    ny = q14_round(y * c + z * s);
    nz = q14_round(z * c - y * s);
    y = ny;
    z = nz;
    c = cos_part(cfg_shadow[REG_PITCH_CS]);
    s = sin_part(cfg_shadow[REG_PITCH_CS]);
    nx = q14_round(x * c - z * s);
    nz = q14_round(x * s + z * c);
    x = nx;
    z = nz;
    c = cos_part(cfg_shadow[REG_YAW_CS]);
    s = sin_part(cfg_shadow[REG_YAW_CS]);
    nx = q14_round(x * c + y * s);
    ny = q14_round(y * c - x * s);
    r.x = nx[31:0];
    r.y = ny[31:0];
    r.z = z[31:0];
    r.last = p.last;
    return r;
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_q.push_back(transform_point(on_wire));
      end
      if (gap_left > 0 || pending_q.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end else begin
        on_wire = pending_q.pop_front();
        start <= 1'b1;
        point_x_i <= on_wire.x;
        point_y_i <= on_wire.y;
        point_z_i <= on_wire.z;
        last_point_i <= on_wire.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  task automatic compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS) begin
        $display("%0t %s mismatch: expected %0d (%h) got %0d (%h)",
                 $time, name, want, want, got, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && strobe_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t result with no request outstanding: expected none got %h %h %h %b",
                 $time, moved_x_o, moved_y_o, moved_z_o, last_moved_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        compare_field("moved_x", want.x, moved_x_o);
        compare_field("moved_y", want.y, moved_y_o);
        compare_field("moved_z", want.z, moved_z_o);
        compare_field("last_moved", {31'd0, want.last}, {31'd0, last_moved_o});
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAIL translate_and_euler_rotate_3d");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < NUM_REGS) begin
      cfg_shadow[idx] = value;
    end
  endtask

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    pending_q.push_back(p);
  endtask

  // wait for every request to come back, then let the pipeline settle
  task automatic drain();
    do begin
      @(posedge clk_i);
    end while (pending_q.size() != 0 || start || expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    int v;
    case ($urandom_range(0, 7))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2: begin
        v = int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        return v;
      end
      3: begin
        v = int'($urandom_range(0, 8)) - 4;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    int v;
    case ($urandom_range(0, 5))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2: return 32'd0;
      3: begin
        v = int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        return v;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_q14();
    int v;
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'($urandom);
      default: begin
        v = int'($urandom_range(0, 32768)) - 16384;
        return v[15:0];
      end
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned n;
    cfg_shadow[REG_OFFSET_X] = OFFSET_RST;
    cfg_shadow[REG_OFFSET_Y] = OFFSET_RST;
    cfg_shadow[REG_OFFSET_Z] = OFFSET_RST;
    cfg_shadow[REG_ROLL_CS]  = CS_RST;
    cfg_shadow[REG_PITCH_CS] = CS_RST;
    cfg_shadow[REG_YAW_CS]   = CS_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: identity rotation, no offset
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_point(Q16_MAX, Q16_MAX, Q16_MAX, 1'b1);
    queue_point(Q16_MIN, Q16_MIN, Q16_MIN, 1'b0);
    queue_point(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    queue_point(32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);
    drain();

    // offset saturation, and half-way rounding with cos 0.5, sin 0
    write_reg(REG_OFFSET_X, Q16_MAX);
    write_reg(REG_OFFSET_Y, Q16_MIN);
    write_reg(REG_OFFSET_Z, 32'd1);
    write_reg(REG_ROLL_CS, 32'h2000_0000);
    write_reg(REG_PITCH_CS, 32'h2000_0000);
    write_reg(REG_YAW_CS, 32'h2000_0000);
    queue_point(32'd1, -32'sd1, 32'd0, 1'b1);
    queue_point(-32'sd1, 32'd1, -32'sd2, 1'b0);
    queue_point(Q16_MIN, Q16_MAX, 32'd2, 1'b1);
    queue_point(32'sd3, -32'sd3, -32'sd4, 1'b0);
    queue_point(-32'sd3, 32'sd3, 32'sd5, 1'b1);
    drain();

    // extreme unnormalised pairs drive the rotation sums into saturation
    write_reg(REG_OFFSET_X, 32'd0);
    write_reg(REG_OFFSET_Y, 32'd0);
    write_reg(REG_OFFSET_Z, 32'd0);
    write_reg(REG_ROLL_CS, 32'h7FFF_7FFF);
    write_reg(REG_PITCH_CS, 32'h8000_8000);
    write_reg(REG_YAW_CS, 32'h8000_7FFF);
    queue_point(Q16_MAX, Q16_MAX, Q16_MAX, 1'b0);
    queue_point(Q16_MIN, Q16_MIN, Q16_MIN, 1'b1);
    queue_point(Q16_MAX, Q16_MIN, Q16_MAX, 1'b0);
    queue_point(32'd1, -32'sd1, 32'd1, 1'b1);
    drain();

    // writes past the register file change nothing
    write_reg(SPARE_IDX_A, $urandom);
    write_reg(SPARE_IDX_B, $urandom);
    write_reg(REG_ROLL_CS, 32'h0000_4000);
    write_reg(REG_PITCH_CS, CS_RST);
    write_reg(REG_YAW_CS, 32'h0000_C000);
    queue_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
    queue_point(-32'sh0001_0000, 32'h0000_8000, -32'sh0004_0000, 1'b1);
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_reg(REG_OFFSET_X, pick_offset());
      write_reg(REG_OFFSET_Y, pick_offset());
      write_reg(REG_OFFSET_Z, pick_offset());
      write_reg(REG_ROLL_CS, {pick_q14(), pick_q14()});
      write_reg(REG_PITCH_CS, {pick_q14(), pick_q14()});
      write_reg(REG_YAW_CS, {pick_q14(), pick_q14()});
      for (n = 0; n < POINTS_PER_SET; n++) begin
        queue_point(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS translate_and_euler_rotate_3d");
    end else begin
      $display("FAIL translate_and_euler_rotate_3d");
    end
    $finish;
  end

endmodule
